### rtl/lru_pkg.sv
`default_nettype none

package lru_pkg;

   // Number of entries the recency stack can hold, and the width of a tag.
   localparam int Ways    = 8;
   localparam int TagBits = 20;

   // Widths: CountW is derived from Ways; WayW and OccW are fixed.
   localparam int CountW = $clog2(Ways + 1);
   localparam int WayW   = 3;
   localparam int OccW   = 4;

   typedef enum logic [1:0] {
      ACT_TOUCH  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_EVICT  = 2'd2,
      ACT_FIND   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [TagBits-1:0] line_tag;
      logic [WayW-1:0]    line_way;
      logic               line_valid;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [TagBits-1:0] out_tag;
      logic [WayW-1:0]    out_way;
      logic               out_valid;
      status_type         status;
      logic [OccW-1:0]    occupancy;
   } rsp_type;

   // One line held in the recency stack.
   typedef struct packed {
      logic [TagBits-1:0] tag;
      logic               valid;
      logic [WayW-1:0]    way;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

endpackage

`default_nettype wire

### rtl/lru_order_tracker.sv
`default_nettype none

// True-LRU replacement stack for one cache set of up to Ways lines.
//
// Requests arrive on the req_ channel (req_valid, req_stall, req_data) and each
// one produces exactly one response on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data). A request is taken at a rising edge with valid high and stall low.
// A request may touch a line by tag (move it to the MRU end), insert a new
// line at MRU, evict the LRU line, or find a line by its way number.
//
// A request that is taken lands in the input register; its response is then
// registered in the response register.
// Throughput: one request per cycle while the receiver does not hold rsp_stall.
// All entries are compared in parallel and the stack is shifted in the same
// pass; the stack update of one request is in place before the next one is
// evaluated.
//
// Reset clears the entry count, so the stack starts empty; the contents of the
// stack itself are not cleared. When the receiver holds rsp_stall, the response
// register keeps its value and the pending request waits in the input register;
// req_stall rises once that register is occupied and cannot drain.
module lru_order_tracker
   import lru_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Input register and response register.
   req_type req_ff;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   // Recency stack: position 0 is MRU, position count-1 is LRU.
   entry_type         stack_ff [Ways];
   entry_type         stack_in [Ways];
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;

   logic [Ways-1:0]   match;
   logic [Ways-1:0]   hit;
   logic [Ways-1:0]   shift_mask;
   logic [Ways-1:0]   lru_sel;
   logic [EntryW-1:0] hit_bits;
   logic [EntryW-1:0] lru_bits;
   entry_type         hit_entry;
   entry_type         lru_entry;
   entry_type         new_entry;
   logic              seen;
   logic              advance;

   // The request in the input register moves on whenever the response
   // register is free or is being emptied in this cycle.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_valid_in = (req_valid && !req_stall) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign new_entry.tag   = req_ff.line_tag;
   assign new_entry.valid = req_ff.line_valid;
   assign new_entry.way   = req_ff.line_way;

   // Compare every occupied position at once. A touch needs a valid line with
   // the same tag; a find only compares the way number.
   always_comb begin
      for (int i = 0; i < Ways; i++) begin
         if (req_ff.action == ACT_TOUCH) begin
            match[i] = (CountW'(i) < count_ff) && stack_ff[i].valid
                       && (stack_ff[i].tag == req_ff.line_tag);
         end else begin
            match[i] = (CountW'(i) < count_ff) && (stack_ff[i].way == req_ff.line_way);
         end
      end
   end

   // Keep only the match nearest to MRU. The shift mask marks the positions
   // from MRU down to the hit, which are the ones that move when a touched
   // line goes to the front.
   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < Ways; i++) begin
         hit[i]        = match[i] && !seen;
         shift_mask[i] = !seen;
         seen          = seen || match[i];
      end
   end

   // One-hot selection of the hit line and of the LRU line.
   always_comb begin
      hit_bits = '0;
      lru_bits = '0;
      for (int i = 0; i < Ways; i++) begin
         lru_sel[i] = (CountW'(i + 1) == count_ff);
         hit_bits   = hit_bits | (stack_ff[i] & {EntryW{hit[i]}});
         lru_bits   = lru_bits | (stack_ff[i] & {EntryW{lru_sel[i]}});
      end
      hit_entry = entry_type'(hit_bits);
      lru_entry = entry_type'(lru_bits);
   end

   // Next stack, next count and the response for the request in the input
   // register.
   always_comb begin
      stack_in         = stack_ff;
      count_in         = count_ff;
      rsp_in.found     = 1'b0;
      rsp_in.out_tag   = '0;
      rsp_in.out_way   = '0;
      rsp_in.out_valid = 1'b0;
      rsp_in.status    = ST_OK;
      unique case (req_ff.action)
         ACT_INSERT: begin
            if (count_ff == CountW'(Ways)) begin
               // A full stack ignores the insert.
               rsp_in.status = ST_FULL;
            end else begin
               for (int i = 1; i < Ways; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_in[0]      = new_entry;
               count_in         = count_ff + CountW'(1);
               rsp_in.found     = 1'b1;
               rsp_in.out_tag   = new_entry.tag;
               rsp_in.out_way   = new_entry.way;
               rsp_in.out_valid = new_entry.valid;
            end
         end
         ACT_EVICT: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               count_in         = count_ff - CountW'(1);
               rsp_in.found     = 1'b1;
               rsp_in.out_tag   = lru_entry.tag;
               rsp_in.out_way   = lru_entry.way;
               rsp_in.out_valid = lru_entry.valid;
            end
         end
         ACT_TOUCH: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (|match) begin
               // Lines above the hit slide down one place and the hit goes to
               // MRU. Touching the MRU line leaves the order as it is.
               for (int i = 1; i < Ways; i++) begin
                  if (shift_mask[i]) begin
                     stack_in[i] = stack_ff[i-1];
                  end
               end
               stack_in[0]      = hit_entry;
               rsp_in.found     = 1'b1;
               rsp_in.out_tag   = hit_entry.tag;
               rsp_in.out_way   = hit_entry.way;
               rsp_in.out_valid = hit_entry.valid;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         ACT_FIND: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (|match) begin
               rsp_in.found     = 1'b1;
               rsp_in.out_tag   = hit_entry.tag;
               rsp_in.out_way   = hit_entry.way;
               rsp_in.out_valid = hit_entry.valid;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      rsp_in.occupancy = OccW'(count_in);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers and the stack contents need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff   <= rsp_in;
         stack_ff <= stack_in;
      end
   end

   // The stack never holds more lines than it has positions.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Ways))
      else $error("entry count exceeds stack depth");

   // A pending response always reports the current entry count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.occupancy == OccW'(count_ff)))
      else $error("response occupancy differs from entry count");

   // A response that matched nothing carries zero line fields and a failure code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |->
         (rsp_ff.out_tag == '0 && rsp_ff.out_way == '0 && !rsp_ff.out_valid
          && rsp_ff.status != ST_OK))
      else $error("miss response carries line data or ok status");

   // A successful insert grows the stack by one line.
   assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.action == ACT_INSERT && count_ff != CountW'(Ways)) |=>
         (count_ff == $past(count_ff) + CountW'(1)))
      else $error("insert did not grow the stack");

   // The entry count only changes when a request is evaluated.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("entry count changed without a request");

endmodule

`default_nettype wire
